// File: src/ahr_pkg.sv
// Shared types and constants for the auto-range histogram unit.
// Holds the transaction payload structs and the controller/datapath interface structs.
// Has no dependencies.
package ahr_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int CFG_W      = 7;
    localparam int BIN_NUM_W  = 6;
    localparam int BIN_TOT_W  = 15;
    localparam logic [CFG_W-1:0] BINS_RESET = 7'd50;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_value;
        logic                last_sample;
    } t_sample_in;

    typedef struct packed {
        logic [BIN_NUM_W-1:0] bin_number;
        logic [BIN_TOT_W-1:0] bin_total;
        logic                 last_bin;
    } t_bin_out;

    typedef struct packed {
        logic run_init;
        logic load;
        logic clr_step;
        logic wdiv_start;
        logic width_latch;
        logic zero_fill;
        logic smp_rd;
        logic sdiv_start;
        logic cnt_rd_q;
        logic cnt_inc;
        logic emit_rd;
        logic run_end;
    } t_ahr_cmd;

    typedef struct packed {
        logic div_done;
        logic width_zero;
        logic held_zero;
        logic clr_last;
        logic smp_last;
        logic emit_last;
    } t_ahr_status;

endpackage

// File: src/ahr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ahr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic                                          i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/ahr_div.sv
// Sequential restoring divider, 32-bit unsigned, one quotient bit per cycle.
// No dependencies; the divisor must be nonzero.
module ahr_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    logic        r_run, n_run;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_dvs, n_dvs;
    logic [32:0] w_shift;
    logic [32:0] w_diff;

    always_comb begin
        w_shift = {r_rem, r_quo[31]};
        w_diff  = w_shift - {1'b0, r_dvs};
        n_run   = r_run;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = '0;
            n_rem = '0;
            n_quo = i_dividend;
            n_dvs = i_divisor;
        end else if (r_run) begin
            if (!w_diff[32]) begin
                n_rem = w_diff[31:0];
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = w_shift[31:0];
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: src/ahr_ctrl.sv
// Controller state machine for the auto-range histogram unit.
// Depends on ahr_pkg for the command and status structs.
module ahr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_last_sample,
    input  ahr_pkg::t_ahr_status i_status,
    output ahr_pkg::t_ahr_cmd    o_cmd,
    output logic                 o_busy
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_CLEAR = 11'b000_0000_0010,
        S_WDIV  = 11'b000_0000_0100,
        S_WCHK  = 11'b000_0000_1000,
        S_ZERO  = 11'b000_0001_0000,
        S_SRD   = 11'b000_0010_0000,
        S_SGO   = 11'b000_0100_0000,
        S_SDIV  = 11'b000_1000_0000,
        S_SINC  = 11'b001_0000_0000,
        S_EMIT  = 11'b010_0000_0000,
        S_FLUSH = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.run_init = 1'b1;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last_sample) begin
                        n_state = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    o_cmd.wdiv_start = 1'b1;
                    n_state = S_WDIV;
                end
            end
            S_WDIV: begin
                if (i_status.div_done) begin
                    o_cmd.width_latch = 1'b1;
                    n_state = S_WCHK;
                end
            end
            S_WCHK: begin
                if (i_status.width_zero) begin
                    n_state = S_ZERO;
                end else if (i_status.held_zero) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_ZERO: begin
                o_cmd.zero_fill = 1'b1;
                n_state = S_EMIT;
            end
            S_SRD: begin
                o_cmd.smp_rd = 1'b1;
                n_state = S_SGO;
            end
            S_SGO: begin
                o_cmd.sdiv_start = 1'b1;
                n_state = S_SDIV;
            end
            S_SDIV: begin
                if (i_status.div_done) begin
                    o_cmd.cnt_rd_q = 1'b1;
                    n_state = S_SINC;
                end
            end
            S_SINC: begin
                o_cmd.cnt_inc = 1'b1;
                n_state = i_status.smp_last ? S_EMIT : S_SRD;
            end
            S_EMIT: begin
                o_cmd.emit_rd = 1'b1;
                if (i_status.emit_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_cmd.run_end = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: src/ahr_dp.sv
// Datapath for the auto-range histogram unit: sample store, range tracking,
// shared divider, bin count memory and result register.
// Depends on ahr_pkg, ahr_ram and ahr_div.
module ahr_dp #(
    parameter int MAX_SAMPLES = 16384,
    parameter int MAX_BINS    = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ahr_pkg::t_ahr_cmd              i_cmd,
    output ahr_pkg::t_ahr_status           o_status,
    input  logic [ahr_pkg::SAMPLE_W-1:0]   i_sample_value,
    input  logic [ahr_pkg::CFG_W-1:0]      i_bins_in_use,
    output ahr_pkg::t_bin_out              o_result,
    output logic                           o_result_strobe
);
    localparam int HW  = $clog2(MAX_SAMPLES + 1);
    localparam int SAW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int BW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

    logic [31:0]   r_min, n_min;
    logic [31:0]   r_max, n_max;
    logic [HW-1:0] r_held, n_held;
    logic [31:0]   r_width, n_width;
    logic [BW-1:0] r_clr, n_clr;
    logic [HW-1:0] r_sidx, n_sidx;
    logic [BW-1:0] r_eidx, n_eidx;
    logic [BW-1:0] r_idx, n_idx;
    logic          r_out_valid;
    logic [BW-1:0] r_out_bin;
    logic          r_out_last;

    logic [8:0]    w_b9;
    logic [8:0]    w_b9c;
    logic [8:0]    w_nb;
    logic [BW-1:0] w_last_bin;
    logic          w_room;
    logic          w_smp_we;
    logic [31:0]   w_smp_rdata;
    logic          w_div_start;
    logic [31:0]   w_dividend;
    logic [31:0]   w_divisor;
    logic          w_div_done;
    logic [31:0]   w_quo;
    logic [BW-1:0] w_q_bin;
    logic          w_cnt_we;
    logic [BW-1:0] w_cnt_waddr;
    logic [HW-1:0] w_cnt_wdata;
    logic          w_cnt_re;
    logic [BW-1:0] w_cnt_raddr;
    logic [HW-1:0] w_cnt_rdata;

    assign w_b9       = {2'b00, i_bins_in_use};
    assign w_b9c      = (w_b9 == 9'd0) ? 9'd1 : w_b9;
    assign w_nb       = (w_b9c > 9'(MAX_BINS)) ? 9'(MAX_BINS) : w_b9c;
    assign w_last_bin = BW'(w_nb - 9'd1);

    assign w_room   = (r_held < HW'(MAX_SAMPLES));
    assign w_smp_we = i_cmd.load & w_room;

    ahr_ram #(
        .WIDTH (32),
        .DEPTH (MAX_SAMPLES)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (w_smp_we),
        .i_waddr (r_held[SAW-1:0]),
        .i_wdata (i_sample_value),
        .i_re    (i_cmd.smp_rd),
        .i_raddr (r_sidx[SAW-1:0]),
        .o_rdata (w_smp_rdata)
    );

    assign w_div_start = i_cmd.wdiv_start | i_cmd.sdiv_start;
    assign w_dividend  = i_cmd.wdiv_start ? (r_max - r_min) : (w_smp_rdata - r_min);
    assign w_divisor   = i_cmd.wdiv_start ? 32'(w_nb) : r_width;

    ahr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_q_bin = (w_quo >= 32'(w_nb)) ? w_last_bin : BW'(w_quo);

    always_comb begin
        w_cnt_we    = 1'b0;
        w_cnt_waddr = r_idx;
        w_cnt_wdata = w_cnt_rdata + HW'(1);
        if (i_cmd.clr_step) begin
            w_cnt_we    = 1'b1;
            w_cnt_waddr = r_clr;
            w_cnt_wdata = '0;
        end else if (i_cmd.zero_fill) begin
            w_cnt_we    = 1'b1;
            w_cnt_waddr = '0;
            w_cnt_wdata = r_held;
        end else if (i_cmd.cnt_inc) begin
            w_cnt_we    = 1'b1;
        end
    end

    assign w_cnt_re    = i_cmd.cnt_rd_q | i_cmd.emit_rd;
    assign w_cnt_raddr = i_cmd.cnt_rd_q ? w_q_bin : r_eidx;

    ahr_ram #(
        .WIDTH (HW),
        .DEPTH (MAX_BINS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_re    (w_cnt_re),
        .i_raddr (w_cnt_raddr),
        .o_rdata (w_cnt_rdata)
    );

    always_comb begin
        n_min   = r_min;
        n_max   = r_max;
        n_held  = r_held;
        n_width = r_width;
        n_clr   = r_clr;
        n_sidx  = r_sidx;
        n_eidx  = r_eidx;
        n_idx   = r_idx;
        if (i_cmd.run_init) begin
            n_clr  = '0;
            n_sidx = '0;
            n_eidx = '0;
        end
        if (w_smp_we) begin
            n_held = r_held + HW'(1);
            if (r_held == '0) begin
                n_min = i_sample_value;
                n_max = i_sample_value;
            end else begin
                if (i_sample_value < r_min) begin
                    n_min = i_sample_value;
                end
                if (i_sample_value > r_max) begin
                    n_max = i_sample_value;
                end
            end
        end
        if (i_cmd.clr_step) begin
            n_clr = r_clr + BW'(1);
        end
        if (i_cmd.width_latch) begin
            n_width = w_quo;
        end
        if (i_cmd.cnt_rd_q) begin
            n_idx = w_q_bin;
        end
        if (i_cmd.cnt_inc) begin
            n_sidx = r_sidx + HW'(1);
        end
        if (i_cmd.emit_rd) begin
            n_eidx = r_eidx + BW'(1);
        end
        if (i_cmd.run_end) begin
            n_held = '0;
            n_min  = '0;
            n_max  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= '0;
            r_max       <= '0;
            r_held      <= '0;
            r_clr       <= '0;
            r_sidx      <= '0;
            r_eidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_min       <= n_min;
            r_max       <= n_max;
            r_held      <= n_held;
            r_clr       <= n_clr;
            r_sidx      <= n_sidx;
            r_eidx      <= n_eidx;
            r_out_valid <= i_cmd.emit_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_width    <= n_width;
        r_idx      <= n_idx;
        r_out_bin  <= r_eidx;
        r_out_last <= (r_eidx == w_last_bin);
    end

    assign o_status.div_done   = w_div_done;
    assign o_status.width_zero = (r_width == 32'd0);
    assign o_status.held_zero  = (r_held == '0);
    assign o_status.clr_last   = (r_clr == w_last_bin);
    assign o_status.smp_last   = (r_sidx == (r_held - HW'(1)));
    assign o_status.emit_last  = (r_eidx == w_last_bin);

    assign o_result.bin_number = ahr_pkg::BIN_NUM_W'(r_out_bin);
    assign o_result.bin_total  = ahr_pkg::BIN_TOT_W'(w_cnt_rdata);
    assign o_result.last_bin   = r_out_last;
    assign o_result_strobe     = r_out_valid;

endmodule

// File: src/auto_range_histogram_unit.sv
// Top level of the auto-range histogram unit: configuration register,
// controller and datapath. Depends on ahr_pkg, ahr_ctrl and ahr_dp.
//
//   channel   direction  handshake                 payload
//   sample    in         start & !busy             i_sample (t_sample_in)
//   result    out        o_result_strobe, 1 cycle  o_result (t_bin_out)
//   config    in         i_cfg_valid & o_cfg_ready i_cfg_data (bins in use)
//
// A sample without the last mark is stored while there is room, and the unit
// stays idle. A last sample starts binning: the N bin counts are cleared in turn,
// the bin width is found on the shared 32-bit divider, then each stored sample is
// read, divided by the width and its bin count read and incremented, or all
// samples are counted in bin 0 in place of the per-sample work when the width is
// zero. Then the N results go out in bin order, and a closing state ends the run.
// Reset is synchronous and active low; each run clears its bin counts first.
// The receiver takes every result as it appears.
module auto_range_histogram_unit #(
    parameter int MAX_SAMPLES = 16384,
    parameter int MAX_BINS    = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  ahr_pkg::t_sample_in           i_sample,
    output logic                          busy,
    output ahr_pkg::t_bin_out             o_result,
    output logic                          o_result_strobe,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ahr_pkg::CFG_W-1:0]     i_cfg_data
);
    logic [ahr_pkg::CFG_W-1:0] r_bins_in_use, n_bins_in_use;
    ahr_pkg::t_ahr_cmd         w_cmd;
    ahr_pkg::t_ahr_status      w_status;

    assign o_cfg_ready   = 1'b1;
    assign n_bins_in_use = i_cfg_valid ? i_cfg_data : r_bins_in_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins_in_use <= ahr_pkg::BINS_RESET;
        end else begin
            r_bins_in_use <= n_bins_in_use;
        end
    end

    ahr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_last_sample (i_sample.last_sample),
        .i_status      (w_status),
        .o_cmd         (w_cmd),
        .o_busy        (busy)
    );

    ahr_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_BINS    (MAX_BINS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_sample_value  (i_sample.sample_value),
        .i_bins_in_use   (r_bins_in_use),
        .o_result        (o_result),
        .o_result_strobe (o_result_strobe)
    );

endmodule

// File: tb/sv/tb_auto_range_histogram_unit.sv
// Self-checking testbench for auto_range_histogram_unit: drives sample runs and bin count
// settings, predicts every bin report and checks each one as it appears.
// Depends on ahr_pkg and the auto_range_histogram_unit RTL.
module tb_auto_range_histogram_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SAMPLES = 16384;
    localparam int MAX_BINS    = 64;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    ahr_pkg::t_sample_in       i_sample = '0;
    logic                      busy;
    ahr_pkg::t_bin_out         o_result;
    logic                      o_result_strobe;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [ahr_pkg::CFG_W-1:0] i_cfg_data = '0;

    logic [ahr_pkg::CFG_W-1:0] bins_setting = ahr_pkg::BINS_RESET;
    logic [31:0]               held_samples[$];
    logic [31:0]               run_lo = '0;
    logic [31:0]               run_hi = '0;
    ahr_pkg::t_bin_out         expected_bins[$];
    int unsigned               mismatch_count = 0;
    bit                        gaps_on = 1'b1;

    auto_range_histogram_unit #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .MAX_BINS(MAX_BINS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .i_sample(i_sample),
        .busy(busy),
        .o_result(o_result),
        .o_result_strobe(o_result_strobe),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < 40) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    task automatic predict_histogram(input ahr_pkg::t_sample_in item);
        int unsigned       nbins;
        logic [31:0]       bin_width;
        logic [31:0]       idx;
        logic [31:0]       counts[MAX_BINS];
        ahr_pkg::t_bin_out rep;
        if (held_samples.size() < MAX_SAMPLES) begin
            if (held_samples.size() == 0) begin
                run_lo = item.sample_value;
                run_hi = item.sample_value;
            end else begin
                if (item.sample_value < run_lo) run_lo = item.sample_value;
                if (item.sample_value > run_hi) run_hi = item.sample_value;
            end
            held_samples.push_back(item.sample_value);
        end
        if (!item.last_sample) return;
        nbins = bins_setting;
        if (nbins == 0) nbins = 1;
        if (nbins > MAX_BINS) nbins = MAX_BINS;
        bin_width = (run_hi - run_lo) / nbins;
        for (int b = 0; b < MAX_BINS; b++) counts[b] = '0;
        if (bin_width == 0) begin
            counts[0] = held_samples.size();
        end else begin
            foreach (held_samples[k]) begin
                idx = (held_samples[k] - run_lo) / bin_width;
                if (idx >= nbins) idx = nbins - 1;
                counts[idx]++;
            end
        end
        for (int b = 0; b < nbins; b++) begin
            rep.bin_number = b[ahr_pkg::BIN_NUM_W-1:0];
            rep.bin_total  = counts[b][ahr_pkg::BIN_TOT_W-1:0];
            rep.last_bin   = (b == nbins - 1);
            expected_bins.push_back(rep);
        end
        held_samples.delete();
        run_lo = '0;
        run_hi = '0;
    endtask

    always @(posedge i_clk) begin
        ahr_pkg::t_bin_out want;
        if (i_rst_n && o_result_strobe) begin
            if (expected_bins.size() == 0) begin
                flag_mismatch($sformatf("unexpected bin report, bin %0d total %0d",
                                        o_result.bin_number, o_result.bin_total));
            end else begin
                want = expected_bins.pop_front();
                if (o_result.bin_number !== want.bin_number)
                    flag_mismatch($sformatf("bin_number got %0d expected %0d",
                                            o_result.bin_number, want.bin_number));
                if (o_result.bin_total !== want.bin_total)
                    flag_mismatch($sformatf("bin %0d bin_total got %0d expected %0d",
                                            want.bin_number, o_result.bin_total,
                                            want.bin_total));
                if (o_result.last_bin !== want.last_bin)
                    flag_mismatch($sformatf("bin %0d last_bin got %0b expected %0b",
                                            want.bin_number, o_result.last_bin,
                                            want.last_bin));
            end
        end
    end

    task automatic send_sample(input logic [31:0] value, input logic is_last);
        int unsigned         gap;
        ahr_pkg::t_sample_in item;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        item.sample_value = value;
        item.last_sample  = is_last;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_sample <= item;
        do @(posedge i_clk); while (busy);
        predict_histogram(item);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (expected_bins.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_bins(input logic [ahr_pkg::CFG_W-1:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        bins_setting = value;
    endtask

    task automatic test_reset_bins();
        send_sample(32'h1234_5678, 1'b1);
    endtask

    task automatic test_field_extremes();
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
    endtask

    task automatic test_zero_width();
        send_sample(32'hA5A5_A5A5, 1'b0);
        send_sample(32'hA5A5_A5A5, 1'b1);
        send_sample(32'd100, 1'b0);
        send_sample(32'd130, 1'b0);
        send_sample(32'd101, 1'b1);
    endtask

    task automatic test_first_sample();
        send_sample(32'hF000_0000, 1'b0);
        send_sample(32'hF000_0010, 1'b0);
        send_sample(32'hEFFF_FFF0, 1'b0);
        send_sample(32'hF000_0100, 1'b1);
    endtask

    task automatic test_bin_count_limits();
        write_bins(7'd0);
        send_sample(32'd10, 1'b0);
        send_sample(32'd30, 1'b1);
        write_bins(7'd127);
        send_sample(32'd0, 1'b0);
        send_sample(32'd64000, 1'b0);
        send_sample(32'd63999, 1'b1);
        write_bins(7'd65);
        send_sample(32'd5, 1'b0);
        send_sample(32'd200, 1'b1);
        write_bins(7'd1);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h0000_0003, 1'b1);
        write_bins(ahr_pkg::BINS_RESET);
    endtask

    task automatic test_random_runs();
        int unsigned sent;
        int unsigned run_len;
        logic [31:0] base;
        logic [31:0] mask;
        sent = 0;
        while (sent < 460) begin
            if ($urandom_range(0, 3) == 0) write_bins(7'($urandom_range(0, 127)));
            gaps_on = ($urandom_range(0, 3) != 0);
            run_len = $urandom_range(1, 24);
            base = $urandom();
            case ($urandom_range(0, 3))
                0: mask = 32'hFFFF_FFFF;
                1: mask = 32'h0000_00FF;
                2: mask = (32'd1 << $urandom_range(0, 6)) - 1;
                default: mask = 32'hFFFF_FFFF >> $urandom_range(0, 31);
            endcase
            for (int i = 0; i < run_len; i++) begin
                send_sample(base + ($urandom() & mask), i == run_len - 1);
            end
            sent += run_len;
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_bins();
        test_field_extremes();
        test_zero_width();
        test_first_sample();
        test_bin_count_limits();
        test_random_runs();
        drain_results();
        repeat (8) @(posedge i_clk);
        if (expected_bins.size() != 0)
            flag_mismatch($sformatf("%0d bin reports never arrived", expected_bins.size()));
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
src/ahr_pkg.sv
src/ahr_ram.sv
src/ahr_div.sv
src/ahr_ctrl.sv
src/ahr_dp.sv
src/auto_range_histogram_unit.sv
tb/sv/tb_auto_range_histogram_unit.sv
